// ===== rtl/idl_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Indexed deque list package
// Word formats, opcodes and status codes shared by the list cells, the top
// level and the checker.
// ----------------------------------------------------------------------------
package idl_pkg;

  localparam logic [2:0] OP_PUSH_FRONT = 3'd0;
  localparam logic [2:0] OP_PUSH_BACK  = 3'd1;
  localparam logic [2:0] OP_POP_FRONT  = 3'd2;
  localparam logic [2:0] OP_POP_BACK   = 3'd3;
  localparam logic [2:0] OP_INSERT_AT  = 3'd4;
  localparam logic [2:0] OP_REMOVE_AT  = 3'd5;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_EMPTY  = 2'd1;
  localparam logic [1:0] ST_BADPOS = 2'd2;
  localparam logic [1:0] ST_FULL   = 2'd3;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [4:0]  position;
    logic [31:0] data_in;
  } in_word_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] data_out;
    logic [4:0]  entry_count;
    logic        is_empty;
  } out_word_t;

  typedef struct packed {
    logic ins;
    logic rem;
  } cell_cmd_t;

endpackage

// ===== rtl/idl_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Indexed deque list cell
// Holds one list element. On an insert it takes the element of its lower
// neighbour or the new value; on a remove it takes that of its upper
// neighbour; its tap shows its element whenever its index equals pos_i.
// ----------------------------------------------------------------------------
module idl_cell #(
  parameter int DATA_WIDTH = 32,
  parameter int IW         = 4,
  parameter int INDEX      = 0
) (
  input  logic                  clk_i,
  input  idl_pkg::cell_cmd_t    cmd_i,
  input  logic [IW-1:0]         pos_i,
  input  logic [DATA_WIDTH-1:0] value_i,
  input  logic [DATA_WIDTH-1:0] left_i,
  input  logic [DATA_WIDTH-1:0] right_i,
  output logic [DATA_WIDTH-1:0] data_o,
  output logic [DATA_WIDTH-1:0] tap_o
);

  localparam logic [IW-1:0] Idx = IW'(INDEX);

  logic [DATA_WIDTH-1:0] data_q;
  logic [DATA_WIDTH-1:0] data_d;

  always_comb begin
    data_d = data_q;
    if (cmd_i.ins) begin
      if (Idx == pos_i) begin
        data_d = value_i;
      end else if (Idx > pos_i) begin
        data_d = left_i;
      end
    end else if (cmd_i.rem) begin
      if (Idx >= pos_i) begin
        data_d = right_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;
  assign tap_o  = (Idx == pos_i) ? data_q : '0;

endmodule

// ===== rtl/indexed_deque_list_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Indexed deque list unit
// Bounded ordered list held in a row of cells, with push, pop, insert and
// remove at any position.
// ----------------------------------------------------------------------------
// Usage:
// Input words carry an opcode, a position and a data word; each accepted
// word gives exactly one output word with a status, the element taken out,
// the element count after the operation and an empty flag.
// Both channels use valid and stall; a word moves at a rising edge with
// valid high and stall low.
// The output word is registered at the edge at which the input word is
// accepted. Throughput is one word per cycle unless a stall holds the
// output, since every cell moves its element to a neighbour in the same
// cycle as the operation. While an output word is held by a stall from the
// receiver, the input channel stalls too, and the held word does not change.
// Reset clears the element count and the output valid; element contents are
// not reset and are only ever read below the count, so the block is ready in
// the first cycle after reset.
// ----------------------------------------------------------------------------
module indexed_deque_list_unit #(
  parameter int CAPACITY   = 16,
  parameter int DATA_WIDTH = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  idl_pkg::in_word_t  in_word_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output idl_pkg::out_word_t out_word_o
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int IW = $clog2(CAPACITY);
  localparam int XW = (CW > 5) ? CW : 5;

  logic [CW-1:0]         cnt_q;
  logic [CW-1:0]         cnt_d;
  logic                  out_valid_q;
  idl_pkg::out_word_t    out_word_q;
  idl_pkg::out_word_t    out_word_d;
  logic                  accept;
  logic                  full;
  logic                  empty;
  logic [XW-1:0]         pos_x;
  logic [XW-1:0]         cnt_x;
  logic [XW-1:0]         cnt_new_x;
  logic [1:0]            status;
  logic                  do_ins;
  logic                  do_rem;
  logic [IW-1:0]         sel_pos;
  idl_pkg::cell_cmd_t    cmd;
  logic [63:0]           din_wide;
  logic [DATA_WIDTH-1:0] value;
  logic [DATA_WIDTH-1:0] taken;
  logic [63:0]           taken_wide;
  logic [DATA_WIDTH-1:0] cell_data [CAPACITY];
  logic [DATA_WIDTH-1:0] cell_tap  [CAPACITY];

  assign accept     = in_valid_i && !in_stall_o;
  assign in_stall_o = out_valid_q && out_stall_i;

  assign full     = (cnt_q == CW'(CAPACITY));
  assign empty    = (cnt_q == '0);
  assign pos_x    = XW'(in_word_i.position);
  assign cnt_x    = XW'(cnt_q);
  assign din_wide = 64'(in_word_i.data_in);
  assign value    = din_wide[DATA_WIDTH-1:0];

  always_comb begin
    status  = idl_pkg::ST_OK;
    do_ins  = 1'b0;
    do_rem  = 1'b0;
    sel_pos = '0;
    case (in_word_i.opcode)
      idl_pkg::OP_PUSH_FRONT: begin
        if (full) begin
          status = idl_pkg::ST_FULL;
        end else begin
          do_ins = 1'b1;
        end
      end
      idl_pkg::OP_PUSH_BACK: begin
        if (full) begin
          status = idl_pkg::ST_FULL;
        end else begin
          do_ins  = 1'b1;
          sel_pos = IW'(cnt_q);
        end
      end
      idl_pkg::OP_POP_FRONT: begin
        if (empty) begin
          status = idl_pkg::ST_EMPTY;
        end else begin
          do_rem = 1'b1;
        end
      end
      idl_pkg::OP_POP_BACK: begin
        if (empty) begin
          status = idl_pkg::ST_EMPTY;
        end else begin
          do_rem  = 1'b1;
          sel_pos = IW'(cnt_q - CW'(1));
        end
      end
      idl_pkg::OP_INSERT_AT: begin
        if (full) begin
          status = idl_pkg::ST_FULL;
        end else if (pos_x > cnt_x) begin
          status = idl_pkg::ST_BADPOS;
        end else begin
          do_ins  = 1'b1;
          sel_pos = IW'(pos_x);
        end
      end
      idl_pkg::OP_REMOVE_AT: begin
        if (pos_x >= cnt_x) begin
          status = idl_pkg::ST_BADPOS;
        end else begin
          do_rem  = 1'b1;
          sel_pos = IW'(pos_x);
        end
      end
      default: begin
        status = idl_pkg::ST_BADPOS;
      end
    endcase
  end

  assign cmd.ins = accept && do_ins;
  assign cmd.rem = accept && do_rem;

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic [DATA_WIDTH-1:0] left;
    logic [DATA_WIDTH-1:0] right;

    if (g == 0) begin : g_first
      assign left = value;
    end else begin : g_inner_l
      assign left = cell_data[g-1];
    end

    if (g == CAPACITY - 1) begin : g_last
      assign right = cell_data[g];
    end else begin : g_inner_r
      assign right = cell_data[g+1];
    end

    idl_cell #(
      .DATA_WIDTH (DATA_WIDTH),
      .IW         (IW),
      .INDEX      (g)
    ) u_cell (
      .clk_i   (clk_i),
      .cmd_i   (cmd),
      .pos_i   (sel_pos),
      .value_i (value),
      .left_i  (left),
      .right_i (right),
      .data_o  (cell_data[g]),
      .tap_o   (cell_tap[g])
    );
  end

  always_comb begin
    taken = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      taken = taken | cell_tap[i];
    end
  end

  assign taken_wide = do_rem ? 64'(taken) : 64'd0;

  always_comb begin
    cnt_d = cnt_q;
    if (do_ins) begin
      cnt_d = cnt_q + CW'(1);
    end else if (do_rem) begin
      cnt_d = cnt_q - CW'(1);
    end
  end

  assign cnt_new_x = XW'(cnt_d);

  always_comb begin
    out_word_d.status      = status;
    out_word_d.data_out    = taken_wide[31:0];
    out_word_d.entry_count = cnt_new_x[4:0];
    out_word_d.is_empty    = (cnt_d == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        cnt_q       <= cnt_d;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_word_q <= out_word_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

endmodule

// ===== rtl/idl_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Indexed deque list checker
// Port-level checks on the handshake and on the consistency of output words,
// attached to the top level by a bind statement.
// ----------------------------------------------------------------------------
module idl_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input idl_pkg::in_word_t  in_word_i,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input idl_pkg::out_word_t out_word_o
);

  logic in_seen;

  assign in_seen = in_valid_i && (in_word_i.opcode == in_word_i.opcode);

  // A stalled output word stays valid and unchanged.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_word_o))
    else $error("stalled output word changed");

  // Every accepted input word yields an output word in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_seen && !in_stall_o |=> out_valid_o)
    else $error("accepted word gave no output word");

  // The input side only stalls while a result is held back.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without a held output word");

  // An empty list shows a zero count.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_word_o.is_empty |-> out_word_o.entry_count == 5'd0)
    else $error("empty flag with a non-zero count");

  // A failed operation takes no element out.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_word_o.status != idl_pkg::ST_OK)
      |-> out_word_o.data_out == 32'd0)
    else $error("failed operation returned data");

endmodule

bind indexed_deque_list_unit idl_checker u_idl_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .in_word_i   (in_word_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_word_o  (out_word_o)
);

// ===== verif/indexed_deque_list_unit_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Indexed deque list unit testbench
// Drives opcode words through the list and checks every output word against
// a behavioural list kept alongside it. A short directed sequence covers the
// empty, invalid position and reserved opcode cases. Random bursts then
// favour growth, shrinkage or neither, so that the list runs full and empty
// many times. Both sides idle at random, the receiver holds off once for a
// long stretch, and the sender pauses once until the list has drained its
// output.
// ----------------------------------------------------------------------------
module indexed_deque_list_unit_test;

  localparam int          LIST_DEPTH   = 16;
  localparam logic [2:0]  OP_RSVD_6    = 3'd6;
  localparam logic [2:0]  OP_RSVD_7    = 3'd7;
  localparam int unsigned CALM_FROM    = 300;
  localparam int unsigned CALM_TO      = 500;
  localparam int unsigned HOLD_AT      = 700;
  localparam int unsigned HOLD_CYCLES  = 80;
  localparam int unsigned PAUSE_AT     = 1000;

  logic               clk_i       = 1'b0;
  logic               rst_ni      = 1'b0;
  logic               in_valid_i  = 1'b0;
  logic               in_stall_o;
  idl_pkg::in_word_t  in_word_i   = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  idl_pkg::out_word_t out_word_o;

  idl_pkg::in_word_t  stim_q[$];
  idl_pkg::out_word_t pending_results[$];
  logic [31:0]        list_elems[$];
  int unsigned        acc_cnt     = 0;
  int unsigned        got_cnt     = 0;
  int unsigned        error_cnt   = 0;
  int unsigned        hold_left   = 0;
  logic               hold_done   = 1'b0;
  logic               pause_done  = 1'b0;
  logic               calm;

  indexed_deque_list_unit DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_word_i   (in_word_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o)
  );

  assign calm = (acc_cnt >= CALM_FROM) && (acc_cnt < CALM_TO);

  // Applies one word to the list and returns the output word it should give.
  function automatic idl_pkg::out_word_t apply_list_op(idl_pkg::in_word_t w);
    idl_pkg::out_word_t r;
    int unsigned n;
    n = list_elems.size();
    r = '0;
    r.status = idl_pkg::ST_OK;
    case (w.opcode)
      idl_pkg::OP_PUSH_FRONT, idl_pkg::OP_PUSH_BACK: begin
        if (n >= LIST_DEPTH) begin
          r.status = idl_pkg::ST_FULL;
        end else if (w.opcode == idl_pkg::OP_PUSH_FRONT) begin
          list_elems.push_front(w.data_in);
        end else begin
          list_elems.push_back(w.data_in);
        end
      end
      idl_pkg::OP_POP_FRONT, idl_pkg::OP_POP_BACK: begin
        if (n == 0) begin
          r.status = idl_pkg::ST_EMPTY;
        end else if (w.opcode == idl_pkg::OP_POP_FRONT) begin
          r.data_out = list_elems.pop_front();
        end else begin
          r.data_out = list_elems.pop_back();
        end
      end
      idl_pkg::OP_INSERT_AT: begin
        if (n >= LIST_DEPTH) begin
          r.status = idl_pkg::ST_FULL;
        end else if (w.position > n) begin
          r.status = idl_pkg::ST_BADPOS;
        end else begin
          list_elems.insert(w.position, w.data_in);
        end
      end
      idl_pkg::OP_REMOVE_AT: begin
        if (w.position >= n) begin
          r.status = idl_pkg::ST_BADPOS;
        end else begin
          r.data_out = list_elems[w.position];
          list_elems.delete(w.position);
        end
      end
      default: begin
        r.status = idl_pkg::ST_BADPOS;
      end
    endcase
    r.entry_count = 5'(list_elems.size());
    r.is_empty    = (list_elems.size() == 0);
    return r;
  endfunction

  function automatic idl_pkg::in_word_t make_word(logic [2:0] op, logic [4:0] pos,
                                                  logic [31:0] d);
    idl_pkg::in_word_t w;
    w.opcode   = op;
    w.position = pos;
    w.data_in  = d;
    return w;
  endfunction

  // Bias 0 favours growth, 1 favours shrinkage, 2 is balanced.
  function automatic idl_pkg::in_word_t random_word(int unsigned bias);
    idl_pkg::in_word_t w;
    int unsigned       r;
    int unsigned       grow_pct;
    r = $urandom_range(0, 99);
    grow_pct = (bias == 0) ? 75 : (bias == 1) ? 25 : 50;
    w.data_in = $urandom();
    if ($urandom_range(0, 9) == 0) begin
      w.position = 5'($urandom());
    end else begin
      w.position = 5'($urandom_range(0, $urandom_range(0, 17)));
    end
    if (r < 3) begin
      w.opcode = $urandom_range(0, 1) ? OP_RSVD_7 : OP_RSVD_6;
    end else if ($urandom_range(0, 99) < grow_pct) begin
      case ($urandom_range(0, 2))
        0:       w.opcode = idl_pkg::OP_PUSH_FRONT;
        1:       w.opcode = idl_pkg::OP_PUSH_BACK;
        default: w.opcode = idl_pkg::OP_INSERT_AT;
      endcase
    end else begin
      case ($urandom_range(0, 2))
        0:       w.opcode = idl_pkg::OP_POP_FRONT;
        1:       w.opcode = idl_pkg::OP_POP_BACK;
        default: w.opcode = idl_pkg::OP_REMOVE_AT;
      endcase
    end
    return w;
  endfunction

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #2ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Driver: after the current word has moved, offers the next one or idles.
  always @(posedge clk_i or negedge rst_ni) begin
    int unsigned taken_now;
    logic        wait_drain;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_word_i  <= '0;
      acc_cnt    <= 0;
      pause_done <= 1'b0;
    end else begin
      taken_now = acc_cnt;
      if (in_valid_i && !in_stall_o) begin
        pending_results.push_back(apply_list_op(in_word_i));
        taken_now = acc_cnt + 1;
        acc_cnt <= taken_now;
      end
      wait_drain = (taken_now >= PAUSE_AT) && !pause_done;
      if (wait_drain && got_cnt == taken_now) begin
        pause_done <= 1'b1;
      end
      if (!in_valid_i || !in_stall_o) begin
        if (wait_drain || stim_q.size() == 0 || (!calm && $urandom_range(0, 99) < 33)) begin
          in_valid_i <= 1'b0;
        end else begin
          in_valid_i <= 1'b1;
          in_word_i  <= stim_q.pop_front();
        end
      end
    end
  end

  // Monitor: checks each accepted output word and drives the stall.
  always @(posedge clk_i or negedge rst_ni) begin
    idl_pkg::out_word_t exp_w;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      got_cnt     <= 0;
      hold_left   <= 0;
      hold_done   <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        got_cnt <= got_cnt + 1;
        if (pending_results.size() == 0) begin
          error_cnt++;
          $display("%0t: unexpected word, expected none, actual %p", $time, out_word_o);
        end else begin
          exp_w = pending_results.pop_front();
          if (out_word_o.status !== exp_w.status) begin
            error_cnt++;
            $display("%0t: status expected %0d actual %0d",
                     $time, exp_w.status, out_word_o.status);
          end
          if (out_word_o.data_out !== exp_w.data_out) begin
            error_cnt++;
            $display("%0t: data_out expected %h actual %h",
                     $time, exp_w.data_out, out_word_o.data_out);
          end
          if (out_word_o.entry_count !== exp_w.entry_count) begin
            error_cnt++;
            $display("%0t: entry_count expected %0d actual %0d",
                     $time, exp_w.entry_count, out_word_o.entry_count);
          end
          if (out_word_o.is_empty !== exp_w.is_empty) begin
            error_cnt++;
            $display("%0t: is_empty expected %0b actual %0b",
                     $time, exp_w.is_empty, out_word_o.is_empty);
          end
        end
      end
      if (!hold_done && acc_cnt >= HOLD_AT) begin
        hold_done   <= 1'b1;
        hold_left   <= HOLD_CYCLES;
        out_stall_i <= 1'b1;
      end else if (hold_left != 0) begin
        hold_left   <= hold_left - 1;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= !calm && ($urandom_range(0, 99) < 33);
      end
    end
  end

  initial begin
    stim_q.push_back(make_word(idl_pkg::OP_POP_FRONT,  5'd0,  32'h0));
    stim_q.push_back(make_word(idl_pkg::OP_POP_BACK,   5'd31, 32'hFFFF_FFFF));
    stim_q.push_back(make_word(idl_pkg::OP_REMOVE_AT,  5'd0,  32'h0));
    stim_q.push_back(make_word(idl_pkg::OP_INSERT_AT,  5'd1,  32'h1234_5678));
    stim_q.push_back(make_word(OP_RSVD_6,              5'd0,  32'hFFFF_FFFF));
    stim_q.push_back(make_word(OP_RSVD_7,              5'd31, 32'h0));
    stim_q.push_back(make_word(idl_pkg::OP_INSERT_AT,  5'd0,  32'hFFFF_FFFF));
    stim_q.push_back(make_word(idl_pkg::OP_PUSH_FRONT, 5'd31, 32'h0000_0000));
    stim_q.push_back(make_word(idl_pkg::OP_PUSH_BACK,  5'd16, 32'hA5A5_A5A5));
    stim_q.push_back(make_word(idl_pkg::OP_INSERT_AT,  5'd3,  32'h5A5A_5A5A));
    stim_q.push_back(make_word(idl_pkg::OP_INSERT_AT,  5'd5,  32'hDEAD_BEEF));
    stim_q.push_back(make_word(idl_pkg::OP_REMOVE_AT,  5'd4,  32'h0));
    stim_q.push_back(make_word(idl_pkg::OP_REMOVE_AT,  5'd31, 32'h0));
    stim_q.push_back(make_word(idl_pkg::OP_REMOVE_AT,  5'd1,  32'h0));
    stim_q.push_back(make_word(idl_pkg::OP_POP_BACK,   5'd0,  32'h0));
    stim_q.push_back(make_word(idl_pkg::OP_POP_FRONT,  5'd0,  32'h0));
    stim_q.push_back(make_word(idl_pkg::OP_REMOVE_AT,  5'd0,  32'h0));
    for (int b = 0; b < 65; b++) begin
      int unsigned bias;
      bias = $urandom_range(0, 2);
      for (int k = 0; k < 20; k++) begin
        stim_q.push_back(random_word(bias));
      end
    end

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    do @(negedge clk_i); while (stim_q.size() != 0 || in_valid_i);
    do @(negedge clk_i); while (got_cnt != acc_cnt);
    repeat (5) @(negedge clk_i);
    if (error_cnt == 0 && pending_results.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
